@@ rtl/gcode_char_tokenizer_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef GCODE_CHAR_TOKENIZER_MACROS_SVH
`define GCODE_CHAR_TOKENIZER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gct_pkg.sv @@
// Shared constants and types for the G-code character tokenizer.
package gct_pkg;

	localparam int MANTISSA_BITS = 48;
	localparam int POSITION_BITS = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NUMBER = 2'd0;
	localparam kind_t KIND_WORD   = 2'd1;
	localparam kind_t KIND_SYMBOL = 2'd2;
	localparam kind_t KIND_ERROR  = 2'd3;

	// One token as the scanner hands it over: magnitude plus sign, not yet negated.
	typedef struct packed {
		kind_t                    kind;
		logic [7:0]               letter;
		logic [MANTISSA_BITS-1:0] magnitude;
		logic                     negative;
		logic [3:0]               frac;
		logic                     has_point;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] column;
	} tok_t;

	// Tokens caused by one byte: tok_a always, tok_b when second is set.
	typedef struct packed {
		logic second;
		tok_t tok_a;
		tok_t tok_b;
	} run_t;

endpackage

@@ rtl/gct_front.sv @@
// Scanner front end: classifies each byte, tracks position, builds token runs.
`include "gcode_char_tokenizer_macros.svh"
module gct_front import gct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       take,
	output logic       push,
	output run_t       run
);

	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_WORD_SIGN  = 3'd1;
	localparam logic [2:0] MODE_NUMBER     = 3'd2;
	localparam logic [2:0] MODE_BAD        = 3'd3;
	localparam logic [2:0] MODE_LINE_SKIP  = 3'd4;
	localparam logic [2:0] MODE_PAREN_SKIP = 3'd5;

	localparam int PW = MANTISSA_BITS + 4;
	localparam logic [PW-1:0] HALF_RANGE = {4'b0, 1'b1, {(MANTISSA_BITS-1){1'b0}}};
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_LPAR  = "(";
	localparam logic [7:0] CH_RPAR  = ")";

	typedef struct packed {
		logic [2:0]               mode;
		logic [7:0]               letter;
		logic                     neg;
		logic [MANTISSA_BITS-1:0] acc;
		logic [3:0]               frac;
		logic                     pt;
		logic                     dig;
		logic [POSITION_BITS-1:0] sline;
		logic [POSITION_BITS-1:0] scol;
	} scan_t;

	scan_t                    scan_q;
	logic [POSITION_BITS-1:0] line_q;
	logic [POSITION_BITS-1:0] col_q;

	scan_t                    scan_d;
	logic [POSITION_BITS-1:0] line_d;
	logic [POSITION_BITS-1:0] col_d;
	tok_t                     tok_a;
	tok_t                     tok_b;
	logic [1:0]               n_tok;
	logic [PW-1:0]            acc_w;
	logic [PW-1:0]            prod;
	logic [PW-1:0]            limit;
	logic                     overflow;
	logic                     is_dig;
	logic                     in_token;
	logic                     fresh;

	function automatic scan_t start_scan(logic [7:0] ltr, logic [POSITION_BITS-1:0] ln,
		logic [POSITION_BITS-1:0] cl);
		scan_t s;
		s        = '0;
		s.letter = ltr;
		s.sline  = ln;
		s.scol   = cl;
		return s;
	endfunction

	// Close out a pending number or word.
	function automatic tok_t finish_tok(scan_t s);
		tok_t t;
		t        = '0;
		t.line   = s.sline;
		t.column = s.scol;
		t.letter = s.letter;
		if (s.mode == MODE_BAD) begin
			t.kind = KIND_ERROR;
		end else if (!s.dig) begin
			if (s.letter == 8'd0 && s.neg && !s.pt) begin
				t.kind   = KIND_SYMBOL;
				t.letter = CH_MINUS;
			end else begin
				t.kind = KIND_ERROR;
			end
		end else begin
			t.kind      = (s.letter != 8'd0) ? KIND_WORD : KIND_NUMBER;
			t.magnitude = s.acc;
			t.negative  = s.neg;
			t.frac      = s.frac;
			t.has_point = s.pt;
		end
		return t;
	endfunction

	function automatic tok_t sym_tok(logic [7:0] ch, logic [POSITION_BITS-1:0] ln,
		logic [POSITION_BITS-1:0] cl);
		tok_t t;
		t        = '0;
		t.kind   = KIND_SYMBOL;
		t.letter = ch;
		t.line   = ln;
		t.column = cl;
		return t;
	endfunction

	// acc * 10 + d as shift-add; over the signed limit, or a sixteenth fraction digit, means overflow
	assign acc_w    = {4'b0, scan_q.acc};
	assign prod     = (acc_w << 3) + (acc_w << 1) + PW'(text_byte[3:0]);
	assign limit    = scan_q.neg ? HALF_RANGE : HALF_RANGE - PW'(1);
	assign overflow = (prod > limit) || (scan_q.pt && scan_q.frac == 4'd15);
	assign is_dig   = text_byte inside {["0":"9"]};
	assign in_token = (scan_q.mode == MODE_WORD_SIGN) || (scan_q.mode == MODE_NUMBER) ||
		(scan_q.mode == MODE_BAD);

	always_comb begin
		scan_d = scan_q;
		tok_a  = '0;
		tok_b  = '0;
		n_tok  = 2'd0;
		fresh  = 1'b0;

		if (in_token) begin
			if (scan_q.mode == MODE_WORD_SIGN && text_byte == CH_MINUS) begin
				scan_d.neg  = 1'b1;
				scan_d.mode = MODE_NUMBER;
			end else if (is_dig) begin
				if (scan_q.mode != MODE_BAD) begin
					if (overflow) begin
						scan_d.mode = MODE_BAD;
					end else begin
						scan_d.acc  = prod[MANTISSA_BITS-1:0];
						scan_d.dig  = 1'b1;
						scan_d.mode = MODE_NUMBER;
						if (scan_q.pt)
							scan_d.frac = scan_q.frac + 4'd1;
					end
				end
			end else if (text_byte == CH_DOT) begin
				if (scan_q.mode != MODE_BAD) begin
					if (scan_q.pt) begin
						scan_d.mode = MODE_BAD;
					end else begin
						scan_d.pt   = 1'b1;
						scan_d.mode = MODE_NUMBER;
					end
				end
			end else begin
				// terminator: close token, then rescan this byte from idle
				tok_a       = finish_tok(scan_q);
				n_tok       = 2'd1;
				scan_d.mode = MODE_IDLE;
				fresh       = 1'b1;
			end
		end else if (scan_q.mode == MODE_LINE_SKIP) begin
			if (text_byte == CH_NL)
				scan_d.mode = MODE_IDLE;
		end else if (scan_q.mode == MODE_PAREN_SKIP) begin
			if (text_byte == CH_RPAR)
				scan_d.mode = MODE_IDLE;
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			scan_d.mode = MODE_IDLE;
			if (is_dig) begin
				scan_d      = start_scan(8'd0, line_q, col_q);
				scan_d.acc  = MANTISSA_BITS'(text_byte[3:0]);
				scan_d.dig  = 1'b1;
				scan_d.mode = MODE_NUMBER;
			end else if (text_byte == CH_DOT) begin
				scan_d      = start_scan(8'd0, line_q, col_q);
				scan_d.pt   = 1'b1;
				scan_d.mode = MODE_NUMBER;
			end else if (text_byte == CH_MINUS) begin
				scan_d      = start_scan(8'd0, line_q, col_q);
				scan_d.neg  = 1'b1;
				scan_d.mode = MODE_NUMBER;
			end else if (text_byte inside {"g", "x", "y", "z"}) begin
				scan_d      = start_scan(text_byte, line_q, col_q);
				scan_d.mode = MODE_WORD_SIGN;
			end else if (text_byte inside {"[", "]", "*", "+"} ||
				(text_byte == CH_SLASH && col_q != POS_ONE)) begin
				if (n_tok == 2'd0)
					tok_a = sym_tok(text_byte, line_q, col_q);
				else
					tok_b = sym_tok(text_byte, line_q, col_q);
				n_tok = n_tok + 2'd1;
			end else if (text_byte == CH_SLASH || text_byte == CH_SEMI) begin
				scan_d.mode = MODE_LINE_SKIP;
			end else if (text_byte == CH_LPAR) begin
				scan_d.mode = MODE_PAREN_SKIP;
			end
		end

		if (text_byte == CH_NL) begin
			line_d = (line_q != POS_MAX) ? line_q + POS_ONE : line_q;
			col_d  = POS_ONE;
		end else begin
			line_d = line_q;
			col_d  = (col_q != POS_MAX) ? col_q + POS_ONE : col_q;
		end

		if (end_of_text) begin
			if (scan_d.mode == MODE_WORD_SIGN || scan_d.mode == MODE_NUMBER ||
				scan_d.mode == MODE_BAD) begin
				if (n_tok == 2'd0)
					tok_a = finish_tok(scan_d);
				else
					tok_b = finish_tok(scan_d);
				n_tok = n_tok + 2'd1;
			end
			scan_d.mode = MODE_IDLE;
			line_d      = POS_ONE;
			col_d       = POS_ONE;
		end
	end

	assign push       = take && (n_tok != 2'd0);
	assign run.second = (n_tok == 2'd2);
	assign run.tok_a  = tok_a;
	assign run.tok_b  = tok_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= start_scan(8'd0, POS_ONE, POS_ONE);
			line_q <= POS_ONE;
			col_q  <= POS_ONE;
		end else if (take) begin
			scan_q <= scan_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

	// a newline always ends a token, so an open token sits on the current line
	`GCT_ASSERT_IMP(a_token_on_line, in_token, scan_q.sline == line_q, "token spans lines")

endmodule

@@ rtl/gct_queue.sv @@
// Short queue of token runs between scanner and output stage.
`include "gcode_char_tokenizer_macros.svh"
module gct_queue import gct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t run_in,
	output logic full,
	input  logic pop,
	output logic valid,
	output run_t run_out
);

	localparam logic [QPTR_BITS:0]   CNT_FULL = (QPTR_BITS+1)'(QUEUE_DEPTH);
	localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);

	run_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full    = (cnt_q == CNT_FULL);
	assign valid   = (cnt_q != '0);
	assign run_out = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= run_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + QPTR_BITS'(1);
			if (pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + QPTR_BITS'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_BITS+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_BITS+1)'(1);
		end
	end

	`GCT_ASSERT_IMP(a_no_overflow, push, !full || pop, "push into full queue")
	`GCT_ASSERT_IMP(a_no_underflow, pop, valid, "pop from empty queue")

endmodule

@@ rtl/gct_back.sv @@
// Output stage: unpacks token runs, applies sign, drives the token channel.
`include "gcode_char_tokenizer_macros.svh"
module gct_back import gct_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  run_t                            q_run,
	output logic                            pop,
	output logic                            token_valid,
	input  logic                            token_ready,
	output logic [1:0]                      token_kind,
	output logic [7:0]                      letter,
	output logic signed [MANTISSA_BITS-1:0] mantissa,
	output logic [3:0]                      fraction_digits,
	output logic                            has_point,
	output logic [POSITION_BITS-1:0]        token_line,
	output logic [POSITION_BITS-1:0]        token_column,
	output logic                            last_of_run
);

	logic                     out_valid_q;
	logic                     hold_valid_q;
	tok_t                     hold_q;
	kind_t                    kind_q;
	logic [7:0]               letter_q;
	logic [MANTISSA_BITS-1:0] mant_q;
	logic [3:0]               frac_q;
	logic                     pt_q;
	logic [POSITION_BITS-1:0] line_q;
	logic [POSITION_BITS-1:0] col_q;
	logic                     last_q;

	logic                     load;
	logic                     fill;
	tok_t                     src;
	logic [MANTISSA_BITS-1:0] src_mant;

	assign load     = !out_valid_q || token_ready;
	assign pop      = load && !hold_valid_q && q_valid;
	assign fill     = load && (hold_valid_q || q_valid);
	assign src      = hold_valid_q ? hold_q : q_run.tok_a;
	assign src_mant = src.negative ? (~src.magnitude + MANTISSA_BITS'(1)) : src.magnitude;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= hold_valid_q || q_valid;
			if (hold_valid_q)
				hold_valid_q <= 1'b0;
			else if (q_valid)
				hold_valid_q <= q_run.second;
		end
	end

	always_ff @(posedge clk) begin
		if (fill) begin
			kind_q   <= src.kind;
			letter_q <= src.letter;
			mant_q   <= src_mant;
			frac_q   <= src.frac;
			pt_q     <= src.has_point;
			line_q   <= src.line;
			col_q    <= src.column;
			last_q   <= hold_valid_q || !q_run.second;
		end
		if (pop)
			hold_q <= q_run.tok_b;
	end

	assign token_valid     = out_valid_q;
	assign token_kind      = kind_q;
	assign letter          = letter_q;
	assign mantissa        = mant_q;
	assign fraction_digits = frac_q;
	assign has_point       = pt_q;
	assign token_line      = line_q;
	assign token_column    = col_q;
	assign last_of_run     = last_q;

	`GCT_ASSERT_IMP(a_hold_behind_out, hold_valid_q, out_valid_q, "held token without output")
	`GCT_ASSERT_IMP(a_not_last_holds, out_valid_q && !last_q, hold_valid_q,
		"run split without held token")
	`GCT_ASSERT_NXT(a_hold_drains, hold_valid_q && token_ready, last_q && out_valid_q,
		"held token not sent as last")

endmodule

@@ rtl/gcode_char_tokenizer.sv @@
// Top level of the streaming G-code character tokenizer.
// Usage:
//   Text channel (text_valid/text_ready): one byte per transfer, text_byte plus
//   end_of_text on the final byte of a program. Token channel
//   (token_valid/token_ready): one token per transfer; last_of_run marks the
//   last token that a given byte produced (a byte yields zero, one or two).
//   A completed token passes through the run queue, then the output register,
//   on its way to the output. Throughput: one byte per cycle on input while
//   the queue is not full, and one token per cycle on output while token_ready
//   is high. A byte that yields two tokens holds the output stage for both; the
//   short run queue between scanner and output stage absorbs that and receiver
//   stalls, and text_ready drops only when the queue is full.
//   Reset (arst_n low) returns the scanner to idle at line 1, column 1 and
//   empties the queue and output stage. end_of_text flushes any open number or
//   word and restarts position counting for the next program.
//   While token_ready is low the presented token and its fields hold steady.
module gcode_char_tokenizer import gct_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            text_valid,
	output logic                            text_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_text,
	output logic                            token_valid,
	input  logic                            token_ready,
	output logic [1:0]                      token_kind,
	output logic [7:0]                      letter,
	output logic signed [MANTISSA_BITS-1:0] mantissa,
	output logic [3:0]                      fraction_digits,
	output logic                            has_point,
	output logic [POSITION_BITS-1:0]        token_line,
	output logic [POSITION_BITS-1:0]        token_column,
	output logic                            last_of_run
);

	logic take;
	logic push;
	logic full;
	logic pop;
	logic q_valid;
	run_t run_in;
	run_t run_out;

	// scanner advances on every input transfer; only runs with tokens are queued
	assign text_ready = !full;
	assign take       = text_valid && text_ready;

	gct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.take        (take),
		.push        (push),
		.run         (run_in)
	);

	gct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.run_in  (run_in),
		.full    (full),
		.pop     (pop),
		.valid   (q_valid),
		.run_out (run_out)
	);

	gct_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_run           (run_out),
		.pop             (pop),
		.token_valid     (token_valid),
		.token_ready     (token_ready),
		.token_kind      (token_kind),
		.letter          (letter),
		.mantissa        (mantissa),
		.fraction_digits (fraction_digits),
		.has_point       (has_point),
		.token_line      (token_line),
		.token_column    (token_column),
		.last_of_run     (last_of_run)
	);

endmodule
